/* hdl/tlfp_pkg.sv */
// ----------------------------------------------------------------------------
// tlfp_pkg
// Shared types and constants for the type-length frame parser.
// ----------------------------------------------------------------------------
package tlfp_pkg;

    localparam int unsigned LenW       = 17;
    localparam int unsigned AddrW      = 3;
    localparam int unsigned DataW      = 32;

    localparam logic [LenW-1:0] MAX_PAYLOAD_LIMIT = 17'd65536;
    localparam logic [LenW-1:0] MAX_PAYLOAD_RESET = 17'd65536;

    localparam logic [AddrW-1:0] REG_MAX_PAYLOAD = 3'd0;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef enum logic [5:0] {
        PH_TYPE = 6'b000001,
        PH_LEN1 = 6'b000010,
        PH_LEN2 = 6'b000100,
        PH_LEN3 = 6'b001000,
        PH_LEN4 = 6'b010000,
        PH_DATA = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] msg_type;
        logic [7:0] payload_byte;
        logic       last_byte;
    } t_result;

endpackage

/* hdl/type_length_frame_parser.sv */
// ----------------------------------------------------------------------------
// type_length_frame_parser
// Splits a byte stream into type / 4-byte length / payload frames.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_rx_byte
//   out     | output    | o_out_valid / i_out_stall| kind, msg_type, byte, last
//   cfg     | APB       | psel / penable / pready  | max_payload at 0x0
//
// One byte per cycle while the output is not stalled; each byte passes the
// input register, then the result register. Dropped header bytes and faulted
// bytes give no transfer. Synchronous active-low reset clears all control
// state and restores the limit to 65536.
// An output stall holds the result; the input register keeps accepting
// until it too is full.
// ----------------------------------------------------------------------------
module type_length_frame_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_kind,
    output logic [7:0]                 o_msg_type,
    output logic [7:0]                 o_payload_byte,
    output logic                       o_last_byte,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tlfp_pkg::AddrW-1:0] paddr,
    input  logic [tlfp_pkg::DataW-1:0] pwdata,
    output logic [tlfp_pkg::DataW-1:0] prdata,
    output logic                       pready
);
    import tlfp_pkg::*;

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    t_result         r_out;
    t_result         result;
    logic [LenW-1:0] limit;
    logic            out_free;
    logic            advance;
    logic            in_take;

    assign out_free    = !r_out.valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;

    tlfp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (limit)
    );

    tlfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_limit  (limit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (out_free) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out.valid;
    assign o_kind         = r_out.kind;
    assign o_msg_type     = r_out.msg_type;
    assign o_payload_byte = r_out.payload_byte;
    assign o_last_byte    = r_out.last_byte;
endmodule

/* hdl/tlfp_cfg.sv */
// ----------------------------------------------------------------------------
// tlfp_cfg
// APB register file holding the payload length limit.
// ----------------------------------------------------------------------------
module tlfp_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tlfp_pkg::AddrW-1:0] paddr,
    input  logic [tlfp_pkg::DataW-1:0] pwdata,
    output logic [tlfp_pkg::DataW-1:0] prdata,
    output logic                       pready,
    output logic [tlfp_pkg::LenW-1:0]  o_limit
);
    import tlfp_pkg::*;

    logic [LenW-1:0] r_max_payload;
    logic            sel_max;
    logic            wr_en;

    assign sel_max = (paddr[AddrW-1:2] == REG_MAX_PAYLOAD[AddrW-1:2]);
    assign wr_en   = psel && penable && pwrite && sel_max;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (wr_en) begin
            r_max_payload <= pwdata[LenW-1:0];
        end
    end

    assign prdata  = sel_max ? {{(DataW-LenW){1'b0}}, r_max_payload} : '0;
    assign o_limit = (r_max_payload > MAX_PAYLOAD_LIMIT) ? MAX_PAYLOAD_LIMIT
                                                         : r_max_payload;
endmodule

/* hdl/tlfp_core.sv */
// ----------------------------------------------------------------------------
// tlfp_core
// Frame state and per-byte decode: header collection, payload count, fault.
// ----------------------------------------------------------------------------
module tlfp_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [7:0]                i_byte,
    input  logic [tlfp_pkg::LenW-1:0] i_limit,
    output tlfp_pkg::t_result         o_result
);
    import tlfp_pkg::*;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_type,  n_type;
    logic [31:0]     r_len,   n_len;
    logic [LenW-1:0] r_left,  n_left;
    logic            r_fault, n_fault;

    logic [31:0]     len_next;
    logic [LenW-1:0] left_dec;
    logic            oversize;

    assign len_next = {r_len[23:0], i_byte};
    assign left_dec = r_left - 1'b1;
    assign oversize = (len_next[31:LenW] != '0) || (len_next[LenW-1:0] > i_limit);

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_len    = r_len;
        n_left   = r_left;
        n_fault  = r_fault;
        o_result = '{valid: 1'b0, kind: KIND_BYTE, msg_type: r_type,
                     payload_byte: 8'd0, last_byte: 1'b0};
        if (i_step && !r_fault) begin
            case (r_phase)
                PH_DATA: begin
                    n_left                = left_dec;
                    o_result.valid        = 1'b1;
                    o_result.payload_byte = i_byte;
                    if (left_dec == '0) begin
                        n_phase            = PH_TYPE;
                        o_result.last_byte = 1'b1;
                    end
                end
                PH_LEN1: begin
                    n_len   = len_next;
                    n_phase = PH_LEN2;
                end
                PH_LEN2: begin
                    n_len   = len_next;
                    n_phase = PH_LEN3;
                end
                PH_LEN3: begin
                    n_len   = len_next;
                    n_phase = PH_LEN4;
                end
                PH_LEN4: begin
                    n_len   = len_next;
                    n_phase = PH_TYPE;
                    if (oversize) begin
                        n_fault            = 1'b1;
                        o_result.valid     = 1'b1;
                        o_result.kind      = KIND_ERROR;
                        o_result.last_byte = 1'b1;
                    end else if (len_next == '0) begin
                        o_result.valid     = 1'b1;
                        o_result.kind      = KIND_EMPTY;
                        o_result.last_byte = 1'b1;
                    end else begin
                        n_left  = len_next[LenW-1:0];
                        n_phase = PH_DATA;
                    end
                end
                default: begin
                    n_type  = i_byte;
                    n_len   = '0;
                    n_phase = PH_LEN1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_type  <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_fault <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_left  <= n_left;
            r_fault <= n_fault;
        end
    end
endmodule

/* hdl/tlfp_checker.sv */
// ----------------------------------------------------------------------------
// tlfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module tlfp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_msg_type,
    input logic [7:0] o_payload_byte,
    input logic       o_last_byte
);
    import tlfp_pkg::*;

    logic r_err_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_kind == KIND_ERROR) begin
            r_err_seen <= 1'b1;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == KIND_BYTE || o_kind == KIND_EMPTY ||
                         o_kind == KIND_ERROR))
        else $error("illegal result kind");

    a_nonbyte_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_BYTE) |-> (o_last_byte && o_payload_byte == 8'd0))
        else $error("empty or error result malformed");

    a_sticky_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_seen |-> !o_out_valid)
        else $error("transfer after length error");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_kind) &&
            $stable(o_msg_type) && $stable(o_payload_byte) && $stable(o_last_byte)))
        else $error("stalled result changed");
endmodule

bind type_length_frame_parser tlfp_checker u_tlfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kind         (o_kind),
    .o_msg_type     (o_msg_type),
    .o_payload_byte (o_payload_byte),
    .o_last_byte    (o_last_byte)
);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for type_length_frame_parser. A cycle-free predictor
// tracks the frame phase, type, length and fault flag for every byte transfer
// and queues the records it expects. Each output transfer is compared with the
// oldest queued record. Both channels idle at random, the limit register is
// rewritten between phases, and the run ends with the sticky length fault.
// ----------------------------------------------------------------------------
module tb_top;
    import tlfp_pkg::*;

    localparam int unsigned IDLE_PCT      = 11;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_BYTES  = 900;
    localparam int unsigned EDGE_LEN      = 96;
    localparam logic [AddrW-1:0] MAXLEN_ADDR = AddrW'(REG_MAX_PAYLOAD * 4);
    localparam logic [AddrW-1:0] UNUSED_ADDR = AddrW'((REG_MAX_PAYLOAD + 1) * 4);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] msg_type;
        logic [7:0] data;
        logic       last;
    } t_deframe_rec;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [7:0]        i_rx_byte;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_kind;
    logic [7:0]        o_msg_type;
    logic [7:0]        o_payload_byte;
    logic              o_last_byte;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AddrW-1:0]  paddr;
    logic [DataW-1:0]  pwdata;
    logic [DataW-1:0]  prdata;
    logic              pready;

    // predictor state
    t_phase            cur_phase;
    logic [7:0]        cur_type;
    logic [31:0]       len_acc;
    logic [LenW-1:0]   bytes_due;
    bit                faulted;
    logic [LenW-1:0]   max_len;

    t_deframe_rec      deframed_q[$];
    int                mismatch_count = 0;
    int                bytes_sent = 0;
    bit                calm = 1'b0;

    type_length_frame_parser DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_msg_type     (o_msg_type),
        .o_payload_byte (o_payload_byte),
        .o_last_byte    (o_last_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    function automatic logic [LenW-1:0] limit_in_force();
        return (max_len > MAX_PAYLOAD_LIMIT) ? MAX_PAYLOAD_LIMIT : max_len;
    endfunction

    function automatic void queue_record(input logic [1:0] kind, input logic [7:0] data,
                                         input logic last);
        t_deframe_rec rec;
        rec.kind     = kind;
        rec.msg_type = cur_type;
        rec.data     = data;
        rec.last     = last;
        deframed_q   = {deframed_q, rec};
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        if (faulted)
            return;
        case (cur_phase)
            PH_DATA: begin
                bytes_due = bytes_due - 1'b1;
                if (bytes_due == '0) begin
                    cur_phase = PH_TYPE;
                    queue_record(KIND_BYTE, b, 1'b1);
                end else begin
                    queue_record(KIND_BYTE, b, 1'b0);
                end
            end
            PH_LEN1: begin
                len_acc   = {len_acc[23:0], b};
                cur_phase = PH_LEN2;
            end
            PH_LEN2: begin
                len_acc   = {len_acc[23:0], b};
                cur_phase = PH_LEN3;
            end
            PH_LEN3: begin
                len_acc   = {len_acc[23:0], b};
                cur_phase = PH_LEN4;
            end
            PH_LEN4: begin
                len_acc   = {len_acc[23:0], b};
                cur_phase = PH_TYPE;
                if (len_acc > 32'(limit_in_force())) begin
                    faulted = 1'b1;
                    queue_record(KIND_ERROR, 8'h00, 1'b1);
                end else if (len_acc == '0) begin
                    queue_record(KIND_EMPTY, 8'h00, 1'b1);
                end else begin
                    bytes_due = len_acc[LenW-1:0];
                    cur_phase = PH_DATA;
                end
            end
            default: begin
                cur_type  = b;
                len_acc   = '0;
                cur_phase = PH_LEN1;
            end
        endcase
    endfunction

    // output side: random stall and in-order compare
    always @(posedge i_clk) begin : out_check
        t_deframe_rec got;
        t_deframe_rec want;
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_kind, o_msg_type, o_payload_byte, o_last_byte};
            if (deframed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer kind %0d type %02h byte %02h last %0b",
                                          got.kind, got.msg_type, got.data, got.last));
            end else begin
                want = deframed_q.pop_front();
                if (got.kind !== want.kind || got.msg_type !== want.msg_type ||
                    got.data !== want.data || got.last !== want.last)
                    report_mismatch($sformatf(
                        "got kind %0d type %02h byte %02h last %0b, want %0d %02h %02h %0b",
                        got.kind, got.msg_type, got.data, got.last,
                        want.kind, want.msg_type, want.data, want.last));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == MAXLEN_ADDR)
            max_len = data[LenW-1:0];
    endtask

    task automatic send_header(input logic [7:0] ftype, input logic [31:0] len);
        send_byte(ftype);
        send_byte(len[31:24]);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    // pause_at: index of the frame byte before which the sender drains, -1 for none
    task automatic send_frame(input logic [7:0] ftype, input int len, input int pause_at);
        logic [31:0] lv;
        lv = 32'(len);
        for (int i = 0; i < len + 5; i++) begin
            if (i == pause_at)
                wait_drain();
            case (i)
                0:       send_byte(ftype);
                1:       send_byte(lv[31:24]);
                2:       send_byte(lv[23:16]);
                3:       send_byte(lv[15:8]);
                4:       send_byte(lv[7:0]);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    task automatic test_basic_frames();
        send_header(8'h00, 32'd1);
        send_byte(8'hFF);
        send_header(8'hFF, 32'd0);
        send_header(8'h5A, 32'd2);
        send_byte(8'h00);
        send_byte(8'h80);
        wait_drain();
    endtask

    task automatic test_limit_register();
        apb_write(MAXLEN_ADDR, 32'd0);
        send_header(8'h11, 32'd0);
        // limit changes while a length is half collected
        send_byte(8'h22);
        send_byte(8'h00);
        send_byte(8'h00);
        wait_drain();
        apb_write(MAXLEN_ADDR, 32'd3);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'hC0);
        send_byte(8'h3C);
        send_byte(8'h01);
        wait_drain();
        // out-of-range index must leave the limit alone
        apb_write(UNUSED_ADDR, 32'd0);
        send_header(8'h33, 32'd1);
        send_byte(8'h7E);
        wait_drain();
        apb_write(MAXLEN_ADDR, 32'hFFFF_FFFF);
        send_header(8'h44, 32'd2);
        send_byte(8'hA5);
        send_byte(8'h5A);
        wait_drain();
        apb_write(MAXLEN_ADDR, 32'h0001_0000);
    endtask

    // frame whose length sits exactly on the limit
    task automatic test_full_length_frame();
        apb_write(MAXLEN_ADDR, 32'(EDGE_LEN));
        send_frame(8'hA5, int'(EDGE_LEN), -1);
        wait_drain();
        apb_write(MAXLEN_ADDR, 32'(MAX_PAYLOAD_RESET));
    endtask

    task automatic test_random_stream();
        int seg;
        int seg_end;
        int cap;
        int len;
        int lim;
        int stop_at;
        logic [DataW-1:0] wdata;
        seg     = 0;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            wait_drain();
            case (seg % 5)
                0:       wdata = 32'h0001_0000;
                1:       wdata = 32'($urandom_range(40, 1));
                2:       wdata = $urandom | 32'h0001_0000;
                3:       wdata = 32'($urandom_range(1000, 256));
                default: wdata = $urandom;
            endcase
            apb_write(MAXLEN_ADDR, wdata);
            calm    = (seg == 2);
            seg_end = bytes_sent + 150;
            while (bytes_sent < seg_end) begin
                lim = int'(limit_in_force());
                cap = ($urandom_range(9) == 0) ? 300 : 24;
                if (cap > lim)
                    cap = lim;
                len = $urandom_range(cap, 0);
                send_frame(8'($urandom), len,
                           (seg % 5 == 3) ? int'($urandom_range(len + 4, 0)) : -1);
            end
            calm = 1'b0;
            seg++;
        end
        wait_drain();
    endtask

    task automatic test_sticky_fault();
        // masked write: bit 16 is kept, so the limit clamps to 65536 and length 5 fits
        apb_write(MAXLEN_ADDR, 32'h0003_0004);
        send_header(8'hC3, 32'd5);
        send_header(8'h01, 32'd1);
        send_byte(8'hEE);
        for (int i = 0; i < 16; i++)
            send_byte(8'($urandom));
        wait_drain();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_rx_byte  <= 8'h00;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cur_phase  = PH_TYPE;
        cur_type   = '0;
        len_acc    = '0;
        bytes_due  = '0;
        faulted    = 1'b0;
        max_len    = MAX_PAYLOAD_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_frames();
        test_limit_register();
        test_full_length_frame();
        test_random_stream();
        test_sticky_fault();

        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && deframed_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
